@@ rtl/lcdseq_pkg.sv @@
// Shared types and codes for the character LCD command sequencer.
package lcdseq_pkg;

   localparam int NUM_REGS = 7;

   typedef logic [NUM_REGS-1:0][7:0] cfg_regs_type;

   localparam logic [2:0] REG_INIT_FIRST  = 3'd0;
   localparam logic [2:0] REG_INIT_SECOND = 3'd1;
   localparam logic [2:0] REG_INIT_THIRD  = 3'd2;
   localparam logic [2:0] REG_INIT_FOURTH = 3'd3;
   localparam logic [2:0] REG_LINE_ONE    = 3'd4;
   localparam logic [2:0] REG_LINE_TWO    = 3'd5;
   localparam logic [2:0] REG_MAX_COLUMN  = 3'd6;

   localparam logic [7:0] RST_INIT_FIRST  = 8'd56;
   localparam logic [7:0] RST_INIT_SECOND = 8'd12;
   localparam logic [7:0] RST_INIT_THIRD  = 8'd1;
   localparam logic [7:0] RST_INIT_FOURTH = 8'd6;
   localparam logic [7:0] RST_LINE_ONE    = 8'd128;
   localparam logic [7:0] RST_LINE_TWO    = 8'd192;
   localparam logic [7:0] RST_MAX_COLUMN  = 8'd15;

   localparam logic [7:0] CLEAR_COMMAND = 8'h01;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_LOAD  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_CLEAR = 3'd3;
   localparam logic [2:0] CMD_MOVE  = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOT_OK = 2'd1;
   localparam logic [1:0] ST_BUSY   = 2'd2;

   localparam logic [1:0] DONE_NONE  = 2'd0;
   localparam logic [1:0] DONE_WRITE = 2'd1;
   localparam logic [1:0] DONE_CLEAR = 2'd2;
   localparam logic [1:0] DONE_MOVE  = 2'd3;

   typedef enum logic [1:0] {
      JOB_IDLE  = 2'd0,
      JOB_WRITE = 2'd1,
      JOB_CLEAR = 2'd2,
      JOB_MOVE  = 2'd3
   } job_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] char_value;
      logic [4:0] char_slot;
      logic [7:0] text_length;
      logic [7:0] line_select;
      logic [7:0] column;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       rs_pin;
      logic       en_pin;
      logic [7:0] bus_byte;
      logic [1:0] done_code;
      logic       ready_res;
   } rsp_type;

endpackage

@@ rtl/char_lcd_command_sequencer_unit.sv @@
// Top level of the character LCD command sequencer: handshakes, registers, core.
//
// One item (a tick or a request) is taken every clock. An accepted item is held
// in the input register, is decided by the sequencer core in a single pass and
// lands in the result register, from which its result is offered; the next
// item may follow immediately. A result that is not taken holds the input
// register, which then stops taking new items until the result moves. The pace
// is set by the one-pass state update and by the character buffer, whose read
// data is registered and prefetched at the next send index. The buffer needs
// no clearing after reset; configuration writes are taken in any cycle.
module char_lcd_command_sequencer_unit #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_char_value,
   input  logic [4:0] req_char_slot,
   input  logic [7:0] req_text_length,
   input  logic [7:0] req_line_select,
   input  logic [7:0] req_column,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_rs_pin,
   output logic       rsp_rw_pin,
   output logic       rsp_en_pin,
   output logic [7:0] rsp_bus_byte,
   output logic [1:0] rsp_done_code,
   output logic       rsp_ready_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);
   import lcdseq_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   cfg_regs_type cfg_ff;
   logic         in_vld_ff;
   req_type      in_ff;
   logic         out_vld_ff;
   rsp_type      out_ff;
   rsp_type      core_result;
   logic         advance;
   logic         fire;

   logic          buf_wr_en;
   logic [AW-1:0] buf_wr_addr;
   logic [7:0]    buf_wr_data;
   logic          buf_rd_en;
   logic [AW-1:0] buf_rd_addr;
   logic [7:0]    buf_rd_data;

   assign advance   = !out_vld_ff || rsp_ready;
   assign fire      = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_INIT_FIRST]  <= RST_INIT_FIRST;
         cfg_ff[REG_INIT_SECOND] <= RST_INIT_SECOND;
         cfg_ff[REG_INIT_THIRD]  <= RST_INIT_THIRD;
         cfg_ff[REG_INIT_FOURTH] <= RST_INIT_FOURTH;
         cfg_ff[REG_LINE_ONE]    <= RST_LINE_ONE;
         cfg_ff[REG_LINE_TWO]    <= RST_LINE_TWO;
         cfg_ff[REG_MAX_COLUMN]  <= RST_MAX_COLUMN;
      end else if (csr_valid && (csr_index < 3'(NUM_REGS))) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (fire) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.cmd         <= req_cmd;
         in_ff.char_value  <= req_char_value;
         in_ff.char_slot   <= req_char_slot;
         in_ff.text_length <= req_text_length;
         in_ff.line_select <= req_line_select;
         in_ff.column      <= req_column;
      end
      if (fire) begin
         out_ff <= core_result;
      end
   end

   lcdseq_core #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .AW          (AW)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_ff),
      .cfg_regs   (cfg_ff),
      .buf_rd_data(buf_rd_data),
      .buf_wr_en  (buf_wr_en),
      .buf_wr_addr(buf_wr_addr),
      .buf_wr_data(buf_wr_data),
      .buf_rd_en  (buf_rd_en),
      .buf_rd_addr(buf_rd_addr),
      .result     (core_result)
   );

   lcdseq_text_buf #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .AW          (AW)
   ) u_text_buf (
      .clock  (clock),
      .wr_en  (buf_wr_en),
      .wr_addr(buf_wr_addr),
      .wr_data(buf_wr_data),
      .rd_en  (buf_rd_en),
      .rd_addr(buf_rd_addr),
      .rd_data(buf_rd_data)
   );

   assign rsp_valid     = out_vld_ff;
   assign rsp_status    = out_ff.status;
   assign rsp_rs_pin    = out_ff.rs_pin;
   assign rsp_rw_pin    = 1'b0;
   assign rsp_en_pin    = out_ff.en_pin;
   assign rsp_bus_byte  = out_ff.bus_byte;
   assign rsp_done_code = out_ff.done_code;
   assign rsp_ready_res = out_ff.ready_res;

   // A finished job always leaves the strobe low and the controller ready.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_done_code != DONE_NONE)) |-> (rsp_ready_res && !rsp_en_pin))
      else $error("completion reported while strobe high or not ready");

   a_ready_strobe_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready_res) |-> !rsp_en_pin)
      else $error("controller ready with enable strobe still high");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_BUSY)) |-> !rsp_ready_res)
      else $error("busy status reported while controller ready");

endmodule

@@ rtl/lcdseq_text_buf.sv @@
// Character buffer with one write port and a registered, write-through read port.
module lcdseq_text_buf #(
   parameter int BUFFER_DEPTH = 32,
   parameter int AW           = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A write to the address being read is passed straight through, so while rd_en
   // is high the read register mirrors the current contents at rd_addr.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lcdseq_core.sv @@
// Sequencer state and per-item decision logic for the LCD controller.
module lcdseq_core #(
   parameter int BUFFER_DEPTH = 32,
   parameter int AW           = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  lcdseq_pkg::req_type      item,
   input  lcdseq_pkg::cfg_regs_type cfg_regs,
   input  logic [7:0]               buf_rd_data,
   output logic                     buf_wr_en,
   output logic [AW-1:0]            buf_wr_addr,
   output logic [7:0]               buf_wr_data,
   output logic                     buf_rd_en,
   output logic [AW-1:0]            buf_rd_addr,
   output lcdseq_pkg::rsp_type      result
);
   import lcdseq_pkg::*;

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

   logic [1:0]    init_step_ff, init_step_in;
   logic          init_fin_ff, init_fin_in;
   job_type       job_ff, job_in;
   logic          strobe_ff, strobe_in;
   logic          select_ff, select_in;
   logic [7:0]    driven_ff, driven_in;
   logic [CW-1:0] send_index_ff, send_index_in;
   logic [CW-1:0] send_count_ff, send_count_in;
   logic [7:0]    target_line_ff, target_line_in;
   logic [7:0]    target_column_ff, target_column_in;

   logic [7:0] slot_wide;
   logic [7:0] move_byte;
   logic       move_bad;
   logic [1:0] status;
   logic [1:0] done;

   assign slot_wide = {3'b000, item.char_slot};
   assign move_byte = target_line_ff + target_column_ff;
   assign move_bad  = ((item.line_select != cfg_regs[REG_LINE_ONE]) &&
                       (item.line_select != cfg_regs[REG_LINE_TWO])) ||
                      (item.column > cfg_regs[REG_MAX_COLUMN]);

   always_comb begin
      init_step_in     = init_step_ff;
      init_fin_in      = init_fin_ff;
      job_in           = job_ff;
      strobe_in        = strobe_ff;
      select_in        = select_ff;
      driven_in        = driven_ff;
      send_index_in    = send_index_ff;
      send_count_in    = send_count_ff;
      target_line_in   = target_line_ff;
      target_column_in = target_column_ff;
      status           = ST_OK;
      done             = DONE_NONE;
      buf_wr_en        = 1'b0;

      if (fire) begin
         unique case (item.cmd)
            CMD_TICK: begin
               if (!init_fin_ff) begin
                  if (strobe_ff) begin
                     strobe_in = 1'b0;
                     if (init_step_ff == 2'd3) begin
                        init_fin_in = 1'b1;
                     end else begin
                        init_step_in = init_step_ff + 2'd1;
                     end
                  end else begin
                     driven_in = cfg_regs[{1'b0, init_step_ff}];
                     select_in = 1'b0;
                     strobe_in = 1'b1;
                  end
               end else begin
                  unique case (job_ff)
                     JOB_WRITE: begin
                        if (strobe_ff) begin
                           strobe_in = 1'b0;
                        end else if (send_index_ff >= send_count_ff) begin
                           job_in        = JOB_IDLE;
                           send_index_in = '0;
                           done          = DONE_WRITE;
                        end else begin
                           driven_in     = buf_rd_data;
                           select_in     = 1'b1;
                           strobe_in     = 1'b1;
                           send_index_in = send_index_ff + CW'(1);
                        end
                     end
                     JOB_CLEAR: begin
                        if (strobe_ff) begin
                           strobe_in = 1'b0;
                           job_in    = JOB_IDLE;
                           done      = DONE_CLEAR;
                        end else begin
                           driven_in = CLEAR_COMMAND;
                           select_in = 1'b0;
                           strobe_in = 1'b1;
                        end
                     end
                     JOB_MOVE: begin
                        if (strobe_ff) begin
                           strobe_in        = 1'b0;
                           job_in           = JOB_IDLE;
                           target_line_in   = '0;
                           target_column_in = '0;
                           done             = DONE_MOVE;
                        end else begin
                           driven_in = move_byte;
                           select_in = 1'b0;
                           strobe_in = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            CMD_LOAD: begin
               if (slot_wide >= DEPTH_B) begin
                  status = ST_NOT_OK;
               end else if (job_ff != JOB_IDLE) begin
                  status = ST_BUSY;
               end else begin
                  buf_wr_en = 1'b1;
               end
            end
            CMD_WRITE: begin
               if ((item.text_length == 8'd0) || (item.text_length > DEPTH_B)) begin
                  status = ST_NOT_OK;
               end else if (job_ff != JOB_IDLE) begin
                  status = ST_BUSY;
               end else begin
                  job_in        = JOB_WRITE;
                  send_index_in = '0;
                  send_count_in = item.text_length[CW-1:0];
               end
            end
            CMD_CLEAR: begin
               if (job_ff != JOB_IDLE) begin
                  status = ST_BUSY;
               end else begin
                  job_in = JOB_CLEAR;
               end
            end
            CMD_MOVE: begin
               if (move_bad) begin
                  status = ST_NOT_OK;
               end else if (job_ff != JOB_IDLE) begin
                  status = ST_BUSY;
               end else begin
                  job_in           = JOB_MOVE;
                  target_line_in   = item.line_select;
                  target_column_in = item.column;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign buf_wr_addr = slot_wide[AW-1:0];
   assign buf_wr_data = item.char_value;

   // The buffer read follows the next send index, so the character for the
   // coming tick is already registered when that tick is processed.
   assign buf_rd_en   = (send_index_in < CW'(BUFFER_DEPTH));
   assign buf_rd_addr = send_index_in[AW-1:0];

   always_comb begin
      result.status    = status;
      result.rs_pin    = select_in;
      result.en_pin    = strobe_in;
      result.bus_byte  = driven_in;
      result.done_code = done;
      result.ready_res = init_fin_in && (job_in == JOB_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_step_ff     <= '0;
         init_fin_ff      <= 1'b0;
         job_ff           <= JOB_IDLE;
         strobe_ff        <= 1'b0;
         select_ff        <= 1'b0;
         driven_ff        <= '0;
         send_index_ff    <= '0;
         send_count_ff    <= '0;
         target_line_ff   <= '0;
         target_column_ff <= '0;
      end else begin
         init_step_ff     <= init_step_in;
         init_fin_ff      <= init_fin_in;
         job_ff           <= job_in;
         strobe_ff        <= strobe_in;
         select_ff        <= select_in;
         driven_ff        <= driven_in;
         send_index_ff    <= send_index_in;
         send_count_ff    <= send_count_in;
         target_line_ff   <= target_line_in;
         target_column_ff <= target_column_in;
      end
   end

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      send_index_ff <= send_count_ff)
      else $error("send index ran past the send count");

   a_init_sticky: assert property (@(posedge clock) disable iff (reset)
      init_fin_ff |=> init_fin_ff)
      else $error("init finished flag dropped without reset");

endmodule

@@ tb/char_lcd_command_sequencer_unit_test.sv @@
// Self-checking testbench for the character LCD command sequencer.
module char_lcd_command_sequencer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdseq_pkg::*;

   localparam int BUF_DEPTH = 32;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [2:0] CMD_UNKNOWN = 3'd5;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_cmd;
   logic [7:0] req_char_value;
   logic [4:0] req_char_slot;
   logic [7:0] req_text_length;
   logic [7:0] req_line_select;
   logic [7:0] req_column;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   logic       rsp_rs_pin;
   logic       rsp_rw_pin;
   logic       rsp_en_pin;
   logic [7:0] rsp_bus_byte;
   logic [1:0] rsp_done_code;
   logic       rsp_ready_res;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_index;
   logic [7:0] csr_data;

   // Model of the sequencer, advanced once per accepted transfer.
   cfg_regs_type lcd_regs = {RST_MAX_COLUMN, RST_LINE_TWO, RST_LINE_ONE, RST_INIT_FOURTH,
                             RST_INIT_THIRD, RST_INIT_SECOND, RST_INIT_FIRST};
   logic [1:0] init_phase = '0;
   logic       init_done = 1'b0;
   job_type    job_now = JOB_IDLE;
   logic       en_level = 1'b0;
   logic       rs_level = 1'b0;
   logic [7:0] bus_level = '0;
   logic [5:0] char_pos = '0;
   logic [5:0] char_total = '0;
   logic [7:0] dest_line = '0;
   logic [7:0] dest_col = '0;
   logic [7:0] glyph_store [BUF_DEPTH];
   bit         glyph_loaded [BUF_DEPTH];

   rsp_type bus_report_q [$];

   bit send_gaps = 1'b1;
   bit take_gaps = 1'b1;
   int failures = 0;
   int items_sent = 0;
   int settings_used = 0;
   int writes_done = 0;
   int clears_done = 0;
   int moves_done = 0;
   int quiet_cycles = 0;

   char_lcd_command_sequencer_unit #(.BUFFER_DEPTH(BUF_DEPTH)) DUT (.*);

   always #2 clock = ~clock;

   function automatic logic [1:0] lcd_tick();
      logic [1:0] fin;
      fin = DONE_NONE;
      if (!init_done) begin
         if (en_level) begin
            en_level = 1'b0;
            if (init_phase == 2'd3) init_done = 1'b1;
            else init_phase = init_phase + 2'd1;
         end else begin
            bus_level = lcd_regs[init_phase];
            rs_level = 1'b0;
            en_level = 1'b1;
         end
         return DONE_NONE;
      end
      case (job_now)
         JOB_WRITE: begin
            if (en_level) begin
               en_level = 1'b0;
            end else if (char_pos >= char_total) begin
               job_now = JOB_IDLE;
               char_pos = '0;
               fin = DONE_WRITE;
               writes_done++;
            end else begin
               bus_level = glyph_store[char_pos[4:0]];
               rs_level = 1'b1;
               en_level = 1'b1;
               char_pos = char_pos + 6'd1;
            end
         end
         JOB_CLEAR: begin
            if (en_level) begin
               en_level = 1'b0;
               job_now = JOB_IDLE;
               fin = DONE_CLEAR;
               clears_done++;
            end else begin
               bus_level = CLEAR_COMMAND;
               rs_level = 1'b0;
               en_level = 1'b1;
            end
         end
         JOB_MOVE: begin
            if (en_level) begin
               en_level = 1'b0;
               job_now = JOB_IDLE;
               dest_line = '0;
               dest_col = '0;
               fin = DONE_MOVE;
               moves_done++;
            end else begin
               bus_level = dest_line + dest_col;
               rs_level = 1'b0;
               en_level = 1'b1;
            end
         end
         default: ;
      endcase
      return fin;
   endfunction

   function automatic rsp_type lcd_sequencer_step(input req_type item);
      rsp_type r;
      logic [1:0] st;
      logic [1:0] fin;
      st = ST_OK;
      fin = DONE_NONE;
      case (item.cmd)
         CMD_TICK: fin = lcd_tick();
         CMD_LOAD: begin
            if (int'(item.char_slot) >= BUF_DEPTH) st = ST_NOT_OK;
            else if (job_now != JOB_IDLE) st = ST_BUSY;
            else begin
               glyph_store[item.char_slot] = item.char_value;
               glyph_loaded[item.char_slot] = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (item.text_length == 8'd0 || int'(item.text_length) > BUF_DEPTH) st = ST_NOT_OK;
            else if (job_now != JOB_IDLE) st = ST_BUSY;
            else begin
               job_now = JOB_WRITE;
               char_pos = '0;
               char_total = item.text_length[5:0];
            end
         end
         CMD_CLEAR: begin
            if (job_now != JOB_IDLE) st = ST_BUSY;
            else job_now = JOB_CLEAR;
         end
         CMD_MOVE: begin
            if ((item.line_select != lcd_regs[REG_LINE_ONE]
                 && item.line_select != lcd_regs[REG_LINE_TWO])
                || item.column > lcd_regs[REG_MAX_COLUMN]) st = ST_NOT_OK;
            else if (job_now != JOB_IDLE) st = ST_BUSY;
            else begin
               job_now = JOB_MOVE;
               dest_line = item.line_select;
               dest_col = item.column;
            end
         end
         default: ;
      endcase
      r.status = st;
      r.rs_pin = rs_level;
      r.en_pin = en_level;
      r.bus_byte = bus_level;
      r.done_code = fin;
      r.ready_res = init_done && (job_now == JOB_IDLE);
      return r;
   endfunction

   function automatic int glyph_prefix();
      int k;
      k = 0;
      while (k < BUF_DEPTH && glyph_loaded[k]) k++;
      return k;
   endfunction

   function automatic req_type request(input logic [2:0] op, input logic [7:0] value,
                                       input logic [4:0] slot, input logic [7:0] len,
                                       input logic [7:0] line, input logic [7:0] col);
      req_type it;
      it.cmd = op;
      it.char_value = value;
      it.char_slot = slot;
      it.text_length = len;
      it.line_select = line;
      it.column = col;
      return it;
   endfunction

   function automatic req_type noise_item();
      return request(3'($urandom_range(0, 7)), 8'($urandom), 5'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      int have;
      gap = send_gaps ? $urandom_range(0, 7) : 0;
      have = glyph_prefix();
      // A write may only send slots that have been loaded since reset.
      if (item.cmd == CMD_WRITE && job_now == JOB_IDLE && item.text_length != 8'd0
          && int'(item.text_length) <= BUF_DEPTH && int'(item.text_length) > have) begin
         if (have == 0) begin
            item.cmd = CMD_LOAD;
            item.char_slot = '0;
         end else begin
            item.text_length = 8'($urandom_range(1, have));
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= item.cmd;
      req_char_value <= item.char_value;
      req_char_slot <= item.char_slot;
      req_text_length <= item.text_length;
      req_line_select <= item.line_select;
      req_column <= item.column;
      do @(posedge clock); while (!req_ready);
      bus_report_q.push_back(lcd_sequencer_step(item));
      if (item.cmd <= CMD_MOVE) items_sent++;
   endtask

   // Ticks until init is over and no job runs; optionally mixes in stray requests.
   task automatic finish_job(input bit noisy);
      while (!(init_done && job_now == JOB_IDLE)) begin
         if (noisy && $urandom_range(0, 99) < 20) send_item(noise_item());
         else send_item(request(CMD_TICK, 8'($urandom), 5'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom)));
      end
   endtask

   task automatic settle_block();
      finish_job(1'b0);
      req_valid <= 1'b0;
      while (bus_report_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_registers(input cfg_regs_type setting);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= setting[i];
         do @(posedge clock); while (!csr_ready);
         lcd_regs[i] = setting[i];
      end
      // The spare index has no register behind it.
      csr_index <= REG_UNUSED;
      csr_data <= 8'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic text_job();
      req_type it;
      int n;
      n = $urandom_range(1, 4);
      repeat (n) begin
         it = noise_item();
         it.cmd = CMD_LOAD;
         if ($urandom_range(0, 1) == 1 && glyph_prefix() < BUF_DEPTH)
            it.char_slot = 5'(glyph_prefix());
         send_item(it);
      end
      it = noise_item();
      it.cmd = CMD_WRITE;
      it.text_length = 8'($urandom_range(1, BUF_DEPTH));
      send_item(it);
      finish_job(1'b1);
   endtask

   task automatic move_job();
      req_type it;
      it = noise_item();
      it.cmd = CMD_MOVE;
      it.line_select = ($urandom_range(0, 1) == 1) ? lcd_regs[REG_LINE_ONE]
                                                  : lcd_regs[REG_LINE_TWO];
      it.column = 8'($urandom_range(0, lcd_regs[REG_MAX_COLUMN]));
      send_item(it);
      finish_job(1'b1);
   endtask

   task automatic random_phase(input int quota);
      int stop_at;
      int pick;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            text_job();
         end else if (pick < 45) begin
            send_item(request(CMD_CLEAR, 8'($urandom), 5'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom)));
            finish_job(1'b1);
         end else if (pick < 70) begin
            move_job();
         end else begin
            send_item(noise_item());
         end
      end
   endtask

   task automatic test_power_up_and_text();
      cfg_regs_type setting;
      setting[REG_INIT_FIRST] = 8'h00;
      setting[REG_INIT_SECOND] = 8'hFF;
      setting[REG_INIT_THIRD] = 8'hA5;
      setting[REG_INIT_FOURTH] = 8'h5A;
      setting[REG_LINE_ONE] = RST_LINE_ONE;
      setting[REG_LINE_TWO] = RST_LINE_TWO;
      setting[REG_MAX_COLUMN] = RST_MAX_COLUMN;
      program_registers(setting);
      // A write issued during init is held and starts once init ends.
      send_item(request(CMD_LOAD, 8'h00, 5'd0, 8'd0, 8'd0, 8'd0));
      send_item(request(CMD_LOAD, 8'hFF, 5'd1, 8'd0, 8'd0, 8'd0));
      send_item(request(CMD_LOAD, 8'hFF, 5'd31, 8'd0, 8'd0, 8'd0));
      send_item(request(CMD_WRITE, 8'd0, 5'd0, 8'd2, 8'd0, 8'd0));
      send_item(request(CMD_CLEAR, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0));
      send_item(request(CMD_WRITE, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0));
      send_item(request(CMD_MOVE, 8'd0, 5'd0, 8'd0, 8'h00, 8'd0));
      repeat (9) send_item(request(CMD_TICK, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0));
      send_item(request(CMD_LOAD, 8'h41, 5'd2, 8'd0, 8'd0, 8'd0));
      send_item(request(CMD_UNKNOWN, 8'hFF, 5'd31, 8'hFF, 8'hFF, 8'hFF));
      finish_job(1'b0);
      send_item(request(CMD_TICK, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0));
   endtask

   task automatic test_cursor_moves();
      send_item(request(CMD_MOVE, 8'd0, 5'd0, 8'd0, lcd_regs[REG_LINE_TWO],
                        lcd_regs[REG_MAX_COLUMN]));
      send_item(request(CMD_MOVE, 8'd0, 5'd0, 8'd0, lcd_regs[REG_LINE_ONE], 8'd0));
      finish_job(1'b0);
      send_item(request(CMD_MOVE, 8'd0, 5'd0, 8'd0, lcd_regs[REG_LINE_ONE],
                        lcd_regs[REG_MAX_COLUMN] + 8'd1));
      send_item(request(CMD_WRITE, 8'd0, 5'd0, 8'd33, 8'd0, 8'd0));
   endtask

   task automatic test_random_mixed_settings();
      cfg_regs_type setting;
      for (int phase = 0; phase < 5; phase++) begin
         for (int r = 0; r < NUM_REGS; r++) setting[r] = 8'($urandom);
         case (phase)
            0: begin
               setting[REG_LINE_ONE] = RST_LINE_ONE;
               setting[REG_LINE_TWO] = RST_LINE_TWO;
               setting[REG_MAX_COLUMN] = RST_MAX_COLUMN;
            end
            1: begin
               // Line code plus column wraps past 255 here.
               setting[REG_LINE_ONE] = 8'hFF;
               setting[REG_LINE_TWO] = 8'h00;
               setting[REG_MAX_COLUMN] = 8'hFF;
            end
            2: begin
               setting[REG_LINE_ONE] = 8'h40;
               setting[REG_LINE_TWO] = 8'h40;
               setting[REG_MAX_COLUMN] = 8'h00;
            end
            default: ;
         endcase
         send_gaps = (phase != 1 && phase != 3);
         take_gaps = (phase != 1 && phase != 2);
         settle_block();
         program_registers(setting);
         random_phase(160);
      end
      send_gaps = 1'b1;
      take_gaps = 1'b1;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bus_report_q.size() == 0) begin
            $display("%0t: result transfer with nothing outstanding, expected none, actual status %0d",
                     $time, rsp_status);
            failures++;
         end else begin
            want = bus_report_q.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("rs_pin", want.rs_pin, rsp_rs_pin);
            check_field("rw_pin", 0, rsp_rw_pin);
            check_field("en_pin", want.en_pin, rsp_en_pin);
            check_field("bus_byte", want.bus_byte, rsp_bus_byte);
            check_field("done_code", want.done_code, rsp_done_code);
            check_field("ready_res", want.ready_res, rsp_ready_res);
         end
      end
   end

   initial begin : result_taker
      int stall;
      rsp_ready <= 1'b0;
      repeat (8) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            stall = take_gaps ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, bus_report_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_TICK;
      req_char_value <= '0;
      req_char_slot <= '0;
      req_text_length <= '0;
      req_line_select <= '0;
      req_column <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_INIT_FIRST;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_power_up_and_text();
      test_cursor_moves();
      test_random_mixed_settings();
      settle_block();
      $display("Sent %0d ticks and requests under %0d register settings.",
               items_sent, settings_used);
      $display("Jobs finished: %0d text writes, %0d clears, %0d cursor moves.",
               writes_done, clears_done, moves_done);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
